[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property in the same cycle as its trigger
`define ASSERT_IMPLY(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error("assertion failed");
// check a property in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("assertion failed");
`endif

[sv/wrts_pkg.sv]
`default_nettype none
package wrts_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_POINTS  = 4096;
   localparam int INDEX_W     = 12;
   localparam int COUNT_W     = 11;
   localparam int POINTS_W    = 13;
   localparam int Y_W         = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int DIV_NUM_W   = 37;
   localparam int DIV_DEN_W   = 24;
   localparam int SAT_W       = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int WEIGHT_ONE  = 256;
   localparam logic [7:0] FRAC_MASK = 8'hFF;

   localparam logic signed [SAT_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
   localparam logic signed [SAT_W-1:0] SAT_LO = 48'shFFFF_8000_0000;
   localparam logic signed [Y_W-1:0]   Y_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [Y_W-1:0]   Y_MIN  = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_FETCH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_TOP    = 3'd2,
      CSR_BOTTOM = 3'd3,
      CSR_FIRST  = 3'd4,
      CSR_LAST   = 3'd5
   } csr_index_type;

   typedef enum logic {
      KIND_FINISH = 1'b0,
      KIND_FETCH  = 1'b1
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CNT_START,
      ST_CNT_WAIT,
      ST_DEF,
      ST_MAP_START,
      ST_MAP_WAIT,
      ST_DEF_DONE,
      ST_BORDER,
      ST_P_WAIT,
      ST_RD_A,
      ST_SET_A,
      ST_A_DONE,
      ST_RD_B,
      ST_SET_B,
      ST_B_DONE,
      ST_MIX,
      ST_NEXT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      cmd_type                        cmd;
      logic [INDEX_W-1:0]             index;
      logic signed [SAMPLE_BITS-1:0]  top_sample;
      logic signed [SAMPLE_BITS-1:0]  bottom_sample;
      logic [COUNT_W-1:0]             sample_count;
      logic signed [SAMPLE_BITS-1:0]  default_value;
      logic                           has_top;
      logic                           has_bottom;
   } req_item_type;

   typedef struct packed {
      kind_type                kind;
      logic [POINTS_W-1:0]     point_count;
      logic signed [Y_W-1:0]   default_y;
      logic signed [Y_W-1:0]   top_y;
      logic signed [Y_W-1:0]   bottom_y;
      logic                    top_valid;
      logic                    bottom_valid;
   } rsp_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic signed [Y_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [Y_W-1:0] r;
      if (v > SAT_HI) begin
         r = Y_MAX;
      end else if (v < SAT_LO) begin
         r = Y_MIN;
      end else begin
         r = v[Y_W-1:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[sv/wrts_div.sv]
`default_nettype none
module wrts_div
   import wrts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   trial;

   assign shifted = {rem_ff, quot_ff[DIV_NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NUM_W);
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[DIV_DEN_W]) begin
            rem_in  = trial[DIV_DEN_W-1:0];
            quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIV_DEN_W-1:0];
            quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

[sv/wrts_queue.sv]
`default_nettype none
module wrts_queue
   import wrts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  req_item_type     push_item,
   input  logic             pop,
   output req_item_type     pop_item,
   output queue_status_type status
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_item_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
endmodule
`default_nettype wire

[sv/wrts_front.sv]
`default_nettype none
module wrts_front
   import wrts_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
)
(
   input  logic                          req_push,
   input  logic [1:0]                    req_cmd,
   input  logic [INDEX_W-1:0]            req_index,
   input  logic signed [SAMPLE_BITS-1:0] req_top_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_bottom_sample,
   input  logic [COUNT_W-1:0]            req_sample_count,
   input  logic signed [SAMPLE_BITS-1:0] req_default_value,
   input  logic                          req_has_top,
   input  logic                          req_has_bottom,
   input  queue_status_type              q_status,
   output logic                          req_full,
   output logic                          q_push,
   output req_item_type                  q_item
);
   cmd_type cmd;
   logic    keep;

   assign cmd = cmd_type'(req_cmd);

   // drop unused codes and loads beyond the store
   always_comb begin
      case (cmd)
         CMD_LOAD:   keep = (32'(req_index) < MAX_SAMPLES);
         CMD_FINISH: keep = 1'b1;
         CMD_FETCH:  keep = 1'b1;
         default:    keep = 1'b0;
      endcase
   end

   always_comb begin
      q_item.cmd           = cmd;
      q_item.index         = req_index;
      q_item.top_sample    = req_top_sample;
      q_item.bottom_sample = req_bottom_sample;
      q_item.sample_count  = (32'(req_sample_count) > MAX_SAMPLES) ?
                             COUNT_W'(MAX_SAMPLES) : req_sample_count;
      q_item.default_value = req_default_value;
      q_item.has_top       = req_has_top;
      q_item.has_bottom    = req_has_bottom;
   end

   assign req_full = q_status.full;
   assign q_push   = req_push && !q_status.full && keep;
endmodule
`default_nettype wire

[sv/wrts_back.sv]
`default_nettype none
module wrts_back
   import wrts_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  queue_status_type      q_status,
   input  req_item_type          q_item,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  out_valid,
   output rsp_item_type          out_item
);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);

   // settings
   logic [11:0]        width_ff;
   logic [11:0]        height_ff;
   logic signed [15:0] vtop_ff;
   logic signed [15:0] vbot_ff;
   logic signed [23:0] first_ff;
   logic signed [23:0] last_ff;

   // wave
   logic [COUNT_W-1:0]            wave_count_ff;
   logic signed [SAMPLE_BITS-1:0] wave_default_ff;
   logic                          top_present_ff;
   logic                          bottom_present_ff;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   cmd_type                       cmd_ff;
   logic [INDEX_W-1:0]            idx_ff;
   logic [POINTS_W-1:0]           points_ff;
   logic signed [Y_W-1:0]         dy_ff;
   logic                          tv_ff, bv_ff, border_ff;
   logic [COUNT_W-1:0]            ofs_ff, nxt_ff;
   logic [7:0]                    frac_ff;
   logic signed [SAMPLE_BITS-1:0] map_s_ff;
   logic signed [Y_W-1:0]         map_v_ff, va_ff, ty_ff, by_ff;
   logic signed [41:0]            prod_a_ff, prod_b_ff;
   logic                          out_valid_ff;
   rsp_item_type                  out_item_ff;

   logic signed [SAMPLE_BITS-1:0] top_mem [MAX_SAMPLES];
   logic signed [SAMPLE_BITS-1:0] bot_mem [MAX_SAMPLES];
   logic signed [SAMPLE_BITS-1:0] rd_top_ff, rd_bot_ff;

   // divider
   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den;

   logic                 out_free, mem_we;
   logic [ADDR_W-1:0]    rd_addr;

   // mapping terms
   logic signed [16:0]            diff;
   logic [16:0]                   diff_mag;
   logic                          neg_scale;
   logic signed [SAMPLE_BITS-1:0] floor_v;
   logic signed [16:0]            s_minus;
   logic signed [29:0]            map_prod;
   logic [28:0]                   map_mag;
   logic                          map_neg;
   logic signed [SAT_W-1:0]       offset48;
   logic signed [SAT_W-1:0]       qv48;
   logic signed [SAT_W-1:0]       v48;
   logic signed [Y_W-1:0]         map_res;

   logic signed [24:0]   range_w;
   logic                 range_pos;
   logic [23:0]          cnt_num;
   logic [COUNT_W-1:0]   c_m1;
   logic [22:0]          p_prod;
   logic [28:0]          ofs_full;
   logic [COUNT_W-1:0]   ofs_new;
   logic [COUNT_W:0]     ofs_inc;
   logic                 direct, cur_valid;
   logic signed [SAMPLE_BITS-1:0] rd_sel;
   logic [8:0]           weight_a;
   logic signed [42:0]   mix_sum;
   logic signed [Y_W-1:0] y_direct, y_mix, y_def;

   assign diff      = {vbot_ff[15], vbot_ff} - {vtop_ff[15], vtop_ff};
   assign neg_scale = diff[16];
   assign diff_mag  = neg_scale ? 17'(-diff) : diff;
   assign floor_v   = neg_scale ? vbot_ff : vtop_ff;
   assign s_minus   = {map_s_ff[SAMPLE_BITS-1], map_s_ff} - {floor_v[SAMPLE_BITS-1], floor_v};
   assign map_prod  = s_minus * $signed({1'b0, height_ff});
   assign map_mag   = map_prod[29] ? 29'(-map_prod) : map_prod[28:0];
   assign map_neg   = map_prod[29] ^ neg_scale;
   assign offset48  = neg_scale ? $signed({28'd0, height_ff, 8'd0}) : '0;
   assign qv48      = $signed({11'd0, div_quot});
   assign v48       = map_neg ? -qv48 : qv48;
   assign map_res   = sat32(v48);

   assign range_w   = {last_ff[23], last_ff} - {first_ff[23], first_ff};
   assign range_pos = !range_w[24] && (range_w != '0);
   assign cnt_num   = 24'(wave_count_ff) * 24'({1'b0, width_ff} + 13'd1);
   assign c_m1      = wave_count_ff - COUNT_W'(1);
   assign p_prod    = 23'(c_m1) * 23'(idx_ff);
   assign ofs_full  = div_quot[36:8];
   assign ofs_new   = (ofs_full > 29'(c_m1)) ? c_m1 : ofs_full[COUNT_W-1:0];
   assign ofs_inc   = {1'b0, ofs_new} + (COUNT_W+1)'(1);
   assign direct    = ({2'b0, wave_count_ff} == points_ff);
   assign cur_valid = border_ff ? bv_ff : tv_ff;
   assign rd_sel    = border_ff ? rd_bot_ff : rd_top_ff;
   assign weight_a  = 9'(WEIGHT_ONE) - {1'b0, frac_ff};
   assign mix_sum   = 43'(prod_a_ff) + 43'(prod_b_ff);
   assign y_direct  = sat32(offset48 + $signed({{16{map_v_ff[31]}}, map_v_ff}));
   assign y_def     = y_direct;
   assign y_mix     = sat32(offset48 + $signed({{13{mix_sum[42]}}, mix_sum[42:8]}));
   assign out_free  = !out_valid_ff || rsp_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && q_item.cmd != CMD_LOAD && out_free) begin
               state_in = ST_CNT_START;
            end
         end
         ST_CNT_START: state_in = range_pos ? ST_CNT_WAIT : ST_DEF;
         ST_CNT_WAIT:  if (div_done) state_in = ST_DEF;
         ST_DEF: begin
            ret_in   = ST_DEF_DONE;
            state_in = ST_MAP_START;
         end
         ST_MAP_START: state_in = (diff == '0) ? ret_ff : ST_MAP_WAIT;
         ST_MAP_WAIT:  if (div_done) state_in = ret_ff;
         ST_DEF_DONE:  state_in = (cmd_ff == CMD_FINISH) ? ST_RESULT : ST_BORDER;
         ST_BORDER: begin
            if (!cur_valid) begin
               state_in = ST_NEXT;
            end else if (direct) begin
               state_in = ST_RD_A;
            end else begin
               state_in = ST_P_WAIT;
            end
         end
         ST_P_WAIT: if (div_done) state_in = ST_RD_A;
         ST_RD_A:   state_in = ST_SET_A;
         ST_SET_A: begin
            ret_in   = ST_A_DONE;
            state_in = ST_MAP_START;
         end
         ST_A_DONE: state_in = direct ? ST_NEXT : ST_RD_B;
         ST_RD_B:   state_in = ST_SET_B;
         ST_SET_B: begin
            ret_in   = ST_B_DONE;
            state_in = ST_MAP_START;
         end
         ST_B_DONE: state_in = ST_MIX;
         ST_MIX:    state_in = ST_NEXT;
         ST_NEXT:   state_in = border_ff ? ST_RESULT : ST_BORDER;
         ST_RESULT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rd_addr   = ADDR_W'(ofs_ff);
      case (state_ff)
         ST_IDLE: begin
            q_pop = !q_status.empty && (q_item.cmd == CMD_LOAD || out_free);
         end
         ST_CNT_START: begin
            div_start = range_pos;
            div_num   = DIV_NUM_W'(cnt_num);
            div_den   = range_w[23:0];
         end
         ST_MAP_START: begin
            div_start = (diff != '0);
            div_num   = {map_mag, 8'd0};
            div_den   = DIV_DEN_W'(diff_mag);
         end
         ST_BORDER: begin
            div_start = cur_valid && !direct;
            div_num   = {6'd0, p_prod, 8'd0};
            div_den   = DIV_DEN_W'(points_ff);
         end
         ST_RD_B: rd_addr = ADDR_W'(nxt_ff);
         default: ;
      endcase
   end

   assign mem_we = q_pop && (q_item.cmd == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         top_mem[ADDR_W'(q_item.index)] <= q_item.top_sample;
         bot_mem[ADDR_W'(q_item.index)] <= q_item.bottom_sample;
      end
      rd_top_ff <= top_mem[rd_addr];
      rd_bot_ff <= bot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff          <= 12'd200;
         height_ff         <= 12'd100;
         vtop_ff           <= 16'sd1;
         vbot_ff           <= -16'sd1;
         first_ff          <= 24'sd0;
         last_ff           <= 24'sd200;
         wave_count_ff     <= '0;
         wave_default_ff   <= '0;
         top_present_ff    <= 1'b0;
         bottom_present_ff <= 1'b0;
         state_ff          <= ST_IDLE;
         ret_ff            <= ST_IDLE;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_WIDTH:  width_ff  <= csr_wdata[11:0];
               CSR_HEIGHT: height_ff <= csr_wdata[11:0];
               CSR_TOP:    vtop_ff   <= csr_wdata[15:0];
               CSR_BOTTOM: vbot_ff   <= csr_wdata[15:0];
               CSR_FIRST:  first_ff  <= csr_wdata[23:0];
               CSR_LAST:   last_ff   <= csr_wdata[23:0];
               default: ;
            endcase
         end
         if (q_pop && q_item.cmd == CMD_FINISH) begin
            wave_count_ff     <= q_item.sample_count;
            wave_default_ff   <= q_item.default_value;
            top_present_ff    <= q_item.has_top;
            bottom_present_ff <= q_item.has_bottom;
         end
         if (state_ff == ST_RESULT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ff <= q_item.cmd;
            idx_ff <= q_item.index;
         end
         ST_CNT_START: if (!range_pos) points_ff <= '0;
         ST_CNT_WAIT: begin
            if (div_done) begin
               points_ff <= (div_quot > DIV_NUM_W'(MAX_POINTS)) ?
                            POINTS_W'(MAX_POINTS) : div_quot[POINTS_W-1:0];
            end
         end
         ST_DEF: map_s_ff <= wave_default_ff;
         ST_MAP_START: if (diff == '0) map_v_ff <= '0;
         ST_MAP_WAIT: if (div_done) map_v_ff <= map_res;
         ST_DEF_DONE: begin
            dy_ff     <= y_def;
            border_ff <= 1'b0;
            if (cmd_ff == CMD_FINISH) begin
               ty_ff <= '0;
               by_ff <= '0;
               tv_ff <= top_present_ff;
               bv_ff <= bottom_present_ff;
            end else begin
               tv_ff <= top_present_ff && ({1'b0, idx_ff} < points_ff);
               bv_ff <= bottom_present_ff && ({1'b0, idx_ff} < points_ff);
            end
         end
         ST_BORDER: begin
            ofs_ff <= COUNT_W'(idx_ff);
            if (!cur_valid) begin
               if (border_ff) by_ff <= dy_ff;
               else           ty_ff <= dy_ff;
            end
         end
         ST_P_WAIT: begin
            if (div_done) begin
               ofs_ff  <= ofs_new;
               nxt_ff  <= (ofs_inc < {1'b0, wave_count_ff}) ? ofs_inc[COUNT_W-1:0] : c_m1;
               frac_ff <= div_quot[7:0] & FRAC_MASK;
            end
         end
         ST_SET_A: map_s_ff <= rd_sel;
         ST_A_DONE: begin
            va_ff <= map_v_ff;
            if (direct) begin
               if (border_ff) by_ff <= y_direct;
               else           ty_ff <= y_direct;
            end
         end
         ST_SET_B: map_s_ff <= rd_sel;
         ST_B_DONE: begin
            prod_a_ff <= va_ff * $signed({1'b0, weight_a});
            prod_b_ff <= map_v_ff * $signed({2'b0, frac_ff});
         end
         ST_MIX: begin
            if (border_ff) by_ff <= y_mix;
            else           ty_ff <= y_mix;
         end
         ST_NEXT: border_ff <= 1'b1;
         ST_RESULT: begin
            out_item_ff.kind         <= (cmd_ff == CMD_FINISH) ? KIND_FINISH : KIND_FETCH;
            out_item_ff.point_count  <= points_ff;
            out_item_ff.default_y    <= dy_ff;
            out_item_ff.top_y        <= ty_ff;
            out_item_ff.bottom_y     <= by_ff;
            out_item_ff.top_valid    <= tv_ff;
            out_item_ff.bottom_valid <= bv_ff;
         end
         default: ;
      endcase
   end

   wrts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
endmodule
`default_nettype wire

[sv/waveform_resample_to_screen.sv]
// Load items are written to the sample stores as they are popped; the back end stays idle.
// Finish and fetch items are handled one at a time in the back end, using a shared
// bit-serial divider (point count, each mapped value and each interpolation position).
// A two-entry queue takes new items while the back end works or a result waits.
// Reset is synchronous, active high: settings return to defaults, the wave is cleared,
// the queue and the result register empty. The sample stores are not cleared.
`default_nettype none
`include "assert_macros.svh"
module waveform_resample_to_screen
   import wrts_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_W-1:0]         csr_addr,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic [INDEX_W-1:0]            req_index,
   input  logic signed [SAMPLE_BITS-1:0] req_top_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_bottom_sample,
   input  logic [COUNT_W-1:0]            req_sample_count,
   input  logic signed [SAMPLE_BITS-1:0] req_default_value,
   input  logic                          req_has_top,
   input  logic                          req_has_bottom,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_kind,
   output logic [POINTS_W-1:0]           rsp_point_count,
   output logic signed [Y_W-1:0]         rsp_default_y,
   output logic signed [Y_W-1:0]         rsp_top_y,
   output logic signed [Y_W-1:0]         rsp_bottom_y,
   output logic                          rsp_top_valid,
   output logic                          rsp_bottom_valid
);
   queue_status_type q_status;
   req_item_type     push_item, pop_item;
   logic             q_push, q_pop, out_valid;
   rsp_item_type     out_item;

   wrts_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .req_push          (req_push),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_top_sample    (req_top_sample),
      .req_bottom_sample (req_bottom_sample),
      .req_sample_count  (req_sample_count),
      .req_default_value (req_default_value),
      .req_has_top       (req_has_top),
      .req_has_bottom    (req_has_bottom),
      .q_status          (q_status),
      .req_full          (req_full),
      .q_push            (q_push),
      .q_item            (push_item)
   );

   wrts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   wrts_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_item  (out_item)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_kind         = out_item.kind;
   assign rsp_point_count  = out_item.point_count;
   assign rsp_default_y    = out_item.default_y;
   assign rsp_top_y        = out_item.top_y;
   assign rsp_bottom_y     = out_item.bottom_y;
   assign rsp_top_valid    = out_item.top_valid;
   assign rsp_bottom_valid = out_item.bottom_valid;

   `ASSERT_IMPLY(a_finish_zero_y, clock, reset, !rsp_empty && !rsp_kind, rsp_top_y == '0 && rsp_bottom_y == '0)
   `ASSERT_IMPLY(a_hold_level, clock, reset, !rsp_empty && rsp_kind && !rsp_top_valid, rsp_top_y == rsp_default_y)
   `ASSERT_IMPLY(a_count_cap, clock, reset, !rsp_empty, rsp_point_count <= POINTS_W'(MAX_POINTS))
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)
endmodule
`default_nettype wire
